@@ hw/rtl/spatial_grid_zone_membership_defines.svh @@
// ----------------------------------------------------------------------------
// spatial grid zone membership assertion macros
// shared concurrent assertion forms for the zone membership block
// ----------------------------------------------------------------------------
`ifndef SPATIAL_GRID_ZONE_MEMBERSHIP_DEFINES_SVH
`define SPATIAL_GRID_ZONE_MEMBERSHIP_DEFINES_SVH

// same-cycle implication
`define SGZM_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgzm same-cycle check failed");

// next-cycle implication
`define SGZM_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgzm next-cycle check failed");

`endif

@@ hw/rtl/sgzm_pkg.sv @@
// ----------------------------------------------------------------------------
// sgzm_pkg
// types and fixed constants of the spatial grid zone membership block
// ----------------------------------------------------------------------------
package sgzm_pkg;

  localparam int KIND_W    = 2;
  localparam int ID_W      = 6;
  localparam int COORD_W   = 9;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] LEVEL_SIZE_RESET = 9'd319;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ACK,
    S_LIST,
    S_DRD,
    S_DWR,
    S_DIVW,
    S_CALC,
    S_ARD,
    S_AWR,
    S_LWR,
    S_QRD,
    S_QACC,
    S_SCAN
  } state_t;

endpackage

@@ hw/rtl/sgzm_div.sv @@
// ----------------------------------------------------------------------------
// sgzm_div
// divider of a coordinate by the constant zone size, by reciprocal
// multiplication: the quotient is registered at start, the remainder is
// registered from it while busy
module sgzm_div #(
  parameter int DIVISOR = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sgzm_pkg::COORD_W-1:0] dividend,
  output logic                        busy,
  output logic [sgzm_pkg::COORD_W-1:0] quotient,
  output logic [sgzm_pkg::COORD_W-1:0] remainder
);
  import sgzm_pkg::*;

  localparam int REC_SHIFT = COORD_W + $clog2(DIVISOR);
  localparam int REC_MUL   = ((1 << REC_SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam int PROD_W    = REC_SHIFT + COORD_W;

  logic [PROD_W-1:0]    prod;
  logic [2*COORD_W-1:0] back;
  logic [COORD_W-1:0]   held;
  logic [COORD_W-1:0]   quo;
  logic [COORD_W-1:0]   rem;
  logic                 pend;

  assign prod = PROD_W'(dividend) * PROD_W'(REC_MUL);
  assign back = (2 * COORD_W)'(quo) * (2 * COORD_W)'(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      held <= dividend;
      quo  <= prod[REC_SHIFT +: COORD_W];
    end
    if (pend) begin
      rem <= held - back[COORD_W-1:0];
    end
  end

  assign busy      = pend;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

@@ hw/rtl/spatial_grid_zone_membership.sv @@
// ----------------------------------------------------------------------------
// spatial_grid_zone_membership
// uniform grid broad phase: zone membership store with update, remove, query
// ----------------------------------------------------------------------------
// One command at a time: busy rises with the accepted item and falls in the
// cycle that shows its last result. After reset the zone memory is swept clear
// over all ZONES_X*ZONES_Y zones, one zone per cycle, with busy high. Update
// and remove do read-modify-writes on the single-port zone memory. Coordinates
// and level sizes are divided by the zone size in a reciprocal multiply
// started at the accept. Update clears a registered entity from its old zones,
// then adds it to its new zones; if no zone lies in the grid it is left
// unregistered. Remove clears a registered entity from its zones. Query reads
// the entity's zones, then scans entity indexes up to the highest member,
// emitting one id per set member; an unregistered entity gets one empty
// result. Results appear with strobe for a single cycle and cannot be stalled.
module spatial_grid_zone_membership #(
  parameter int ZONE_SIZE    = 20,
  parameter int ZONES_X      = 16,
  parameter int ZONES_Y      = 16,
  parameter int MAX_ENTITIES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [sgzm_pkg::KIND_W-1:0]    kind,
  input  logic [sgzm_pkg::ID_W-1:0]      entity_id,
  input  logic [sgzm_pkg::COORD_W-1:0]   coord_x,
  input  logic [sgzm_pkg::COORD_W-1:0]   coord_y,
  output logic                           strobe,
  output logic [sgzm_pkg::ID_W-1:0]      member_id,
  output logic                           found,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sgzm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgzm_pkg::CFG_W-1:0]     cfg_data
);
  import sgzm_pkg::*;

  localparam int ZONE_COUNT = ZONES_X * ZONES_Y;
  localparam int ZW         = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
  localparam int IDX_W      = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
  localparam int LIST_W     = 4 * ZW + 3;
  localparam int CW         = COORD_W + 1;
  localparam int PW         = 2 * CW;

  localparam logic [MAX_ENTITIES-1:0] ENTITY_ONE = {{(MAX_ENTITIES - 1){1'b0}}, 1'b1};

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0]        level_width;
  logic [CFG_W-1:0]        level_height;
  logic [KIND_W-1:0]       kind_r;
  logic [IDX_W-1:0]        id_r;
  logic [MAX_ENTITIES-1:0] registered;
  logic [ZW-1:0]           clr;
  logic [1:0]              k;
  logic [MAX_ENTITIES-1:0] acc;
  logic [IDX_W-1:0]        scan;
  logic [ZW-1:0]           cand_z [4];
  logic [2:0]              cand_n;

  logic [MAX_ENTITIES-1:0] zmem [ZONE_COUNT];
  logic [MAX_ENTITIES-1:0] zrd;
  logic [LIST_W-1:0]       lmem [MAX_ENTITIES];
  logic [LIST_W-1:0]       lrd;

  logic                    accept;
  logic                    in_ok;
  logic                    in_reg;
  logic [ZW-1:0]           z_addr;
  logic                    z_we;
  logic [MAX_ENTITIES-1:0] z_wdata;
  logic [MAX_ENTITIES-1:0] id_bit;
  logic [2:0]              lcnt;
  logic                    last_k;
  logic                    last_add;
  logic [MAX_ENTITIES-1:0] scan_bit;
  logic [MAX_ENTITIES-1:0] rest;
  logic [LIST_W-1:0]       l_wdata;
  logic                    div_busy;

  logic [COORD_W-1:0] xq, yq, wq, hq, xr, yr, wr_unused, hr_unused;
  logic bx, by, bw, bh;

  logic [ZW-1:0] sel_z [4];
  logic [2:0]    sel_n;

  sgzm_div #(.DIVISOR(ZONE_SIZE)) u_div_x (
    .clk(clk), .rst(rst), .start(accept), .dividend(coord_x),
    .busy(bx), .quotient(xq), .remainder(xr)
  );
  sgzm_div #(.DIVISOR(ZONE_SIZE)) u_div_y (
    .clk(clk), .rst(rst), .start(accept), .dividend(coord_y),
    .busy(by), .quotient(yq), .remainder(yr)
  );
  sgzm_div #(.DIVISOR(ZONE_SIZE)) u_div_w (
    .clk(clk), .rst(rst), .start(accept), .dividend(level_width),
    .busy(bw), .quotient(wq), .remainder(wr_unused)
  );
  sgzm_div #(.DIVISOR(ZONE_SIZE)) u_div_h (
    .clk(clk), .rst(rst), .start(accept), .dividend(level_height),
    .busy(bh), .quotient(hq), .remainder(hr_unused)
  );

  function automatic logic [ZW-1:0] zone_index(input logic [CW-1:0] zx,
                                              input logic [CW-1:0] zy);
    logic [PW-1:0] p;
    p = PW'(zy) * PW'(ZONES_X) + PW'(zx);
    return p[ZW-1:0];
  endfunction

  assign busy      = state != S_IDLE;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign div_busy  = bx | by | bw | bh;
  assign in_ok     = (ID_W + 1)'(entity_id) < (ID_W + 1)'(MAX_ENTITIES);
  assign in_reg    = in_ok && registered[entity_id[IDX_W-1:0]];
  assign id_bit    = ENTITY_ONE << id_r;
  assign lcnt      = lrd[4*ZW +: 3];
  assign last_k    = (3'(k) + 3'd1) == lcnt;
  assign last_add  = (3'(k) + 3'd1) == cand_n;
  assign scan_bit  = ENTITY_ONE << scan;
  assign rest      = acc & ~scan_bit;
  assign l_wdata   = {cand_n, cand_z[3], cand_z[2], cand_z[1], cand_z[0]};

  // candidate zones of an update, packed in order
  always_comb begin
    logic [CW-1:0] cols, rows, x, y, xn, yn;
    logic          ex_lo, ex_hi, ey_lo, ey_hi, edge_x, edge_y;
    logic [CW-1:0] cx [4];
    logic [CW-1:0] cy [4];
    logic          ok [4];
    cols   = (CW'(wq) + 1'b1 > CW'(ZONES_X)) ? CW'(ZONES_X) : CW'(wq) + 1'b1;
    rows   = (CW'(hq) + 1'b1 > CW'(ZONES_Y)) ? CW'(ZONES_Y) : CW'(hq) + 1'b1;
    x      = CW'(xq);
    y      = CW'(yq);
    ex_lo  = (xr == '0) && (x != '0);
    ex_hi  = !ex_lo && (CW'(xr) == CW'(ZONE_SIZE - 1)) && (x != cols - 1'b1);
    ey_lo  = (yr == '0) && (y != '0);
    ey_hi  = !ey_lo && (CW'(yr) == CW'(ZONE_SIZE - 1)) && (y != rows - 1'b1);
    edge_x = ex_lo | ex_hi;
    edge_y = ey_lo | ey_hi;
    xn     = ex_lo ? x - 1'b1 : x + 1'b1;
    yn     = ey_lo ? y - 1'b1 : y + 1'b1;
    cx[0] = x;  cy[0] = y;  ok[0] = 1'b1;
    cx[1] = xn; cy[1] = y;  ok[1] = edge_x;
    cx[2] = x;  cy[2] = yn; ok[2] = edge_y;
    cx[3] = xn; cy[3] = yn; ok[3] = edge_x && edge_y;
    sel_n = '0;
    for (int i = 0; i < 4; i++) begin
      sel_z[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      if (ok[i] && (cx[i] < cols) && (cy[i] < rows)) begin
        sel_z[sel_n[1:0]] = zone_index(cx[i], cy[i]);
        sel_n = sel_n + 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr == ZW'(ZONE_COUNT - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          case (kind)
            KIND_UPDATE: state_next = !in_ok ? S_ACK : (in_reg ? S_LIST : S_DIVW);
            KIND_REMOVE: state_next = in_reg ? S_LIST : S_ACK;
            KIND_QUERY:  state_next = in_reg ? S_LIST : S_ACK;
            default:     state_next = S_ACK;
          endcase
        end
      end
      S_LIST: state_next = (kind_r == KIND_QUERY) ? S_QRD : S_DRD;
      S_DRD:  state_next = S_DWR;
      S_DWR: begin
        if (last_k) state_next = (kind_r == KIND_UPDATE) ? S_DIVW : S_ACK;
        else        state_next = S_DRD;
      end
      S_DIVW: if (!div_busy) state_next = S_CALC;
      S_CALC: state_next = (sel_n == '0) ? S_ACK : S_ARD;
      S_ARD:  state_next = S_AWR;
      S_AWR:  state_next = last_add ? S_LWR : S_ARD;
      S_LWR:  state_next = S_ACK;
      S_QRD:  state_next = S_QACC;
      S_QACC: state_next = last_k ? S_SCAN : S_QRD;
      S_SCAN: if ((acc == '0) || (acc[scan] && (rest == '0))) state_next = S_IDLE;
      S_ACK:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // zone memory port control
  always_comb begin
    z_addr  = lrd[k*ZW +: ZW];
    z_we    = 1'b0;
    z_wdata = zrd & ~id_bit;
    case (state)
      S_CLEAR: begin
        z_addr  = clr;
        z_we    = 1'b1;
        z_wdata = '0;
      end
      S_DWR: z_we = 1'b1;
      S_ARD: z_addr = cand_z[k];
      S_AWR: begin
        z_addr  = cand_z[k];
        z_we    = 1'b1;
        z_wdata = zrd | id_bit;
      end
      default: z_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (z_we) zmem[z_addr] <= z_wdata;
    zrd <= zmem[z_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_LWR) lmem[id_r] <= l_wdata;
    lrd <= lmem[id_r];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      level_width  <= LEVEL_SIZE_RESET;
      level_height <= LEVEL_SIZE_RESET;
      registered   <= '0;
      clr          <= '0;
      strobe       <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == S_ACK) || ((state == S_SCAN) && ((acc == '0) || acc[scan]));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LEVEL_WIDTH:  level_width  <= cfg_data;
          REG_LEVEL_HEIGHT: level_height <= cfg_data;
          default: level_width <= level_width;
        endcase
      end
      if (state == S_CLEAR) clr <= clr + 1'b1;
      if (state == S_DWR && last_k) registered[id_r] <= 1'b0;
      if (state == S_LWR) registered[id_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind;
      id_r   <= entity_id[IDX_W-1:0];
    end
    case (state)
      S_IDLE: k <= '0;
      S_LIST: begin
        acc  <= '0;
        scan <= '0;
      end
      S_DWR, S_AWR, S_QACC: begin
        k <= (state == S_AWR ? last_add : last_k) ? 2'd0 : k + 1'b1;
        if (state == S_QACC) acc <= acc | zrd;
      end
      S_CALC: begin
        cand_z <= sel_z;
        cand_n <= sel_n;
        k      <= '0;
      end
      S_SCAN: begin
        scan <= scan + 1'b1;
        if (acc[scan]) acc <= rest;
      end
      default: k <= k;
    endcase
    if (state == S_SCAN && acc != '0) begin
      found     <= acc[scan];
      last      <= rest == '0;
      member_id <= ID_W'(scan);
    end else begin
      found     <= 1'b0;
      last      <= 1'b1;
      member_id <= '0;
    end
  end

  `include "spatial_grid_zone_membership_defines.svh"

  `SGZM_ASSERT_IMPLY(a_strobe_after_busy, clk, rst, strobe, $past(busy))
  `SGZM_ASSERT_NEXT(a_accept_goes_busy, clk, rst, start && !busy, busy)
  `SGZM_ASSERT_IMPLY(a_empty_is_last, clk, rst, strobe && !found, last)
  `SGZM_ASSERT_IMPLY(a_found_has_strobe, clk, rst, found, strobe)

endmodule
